FILE: design/vde_pkg.sv
// Shared types and constants for the vector distance engine.
package vde_pkg;

  localparam int ElemW  = 16;
  localparam int MagW   = ElemW + 1;
  localparam int AccW   = 64;
  localparam int OutW   = 48;
  localparam int NumW   = MagW + 16;
  localparam int DivCntW = $clog2(NumW);
  localparam int RootW  = (AccW + 16) / 2;
  localparam int SqCntW = $clog2(RootW);

  typedef enum logic [1:0] {
    MODE_MANH = 2'd0,
    MODE_EUCL = 2'd1,
    MODE_CHEB = 2'd2,
    MODE_CANB = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_TERM,
    ST_DIV_INIT,
    ST_DIV,
    ST_ADD,
    ST_SQ_INIT,
    ST_SQ,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic in_ready;
    logic prep;
    logic term;
    logic div_init;
    logic div_step;
    logic add;
    logic sq_init;
    logic sq_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic canb_div;
    logic last;
    logic sq_need;
    logic div_done;
    logic sq_done;
    logic out_busy;
  } sts_t;

endpackage

FILE: design/vector_distance_engine_unit.sv
// Top level of the vector distance engine: controller plus datapath.
//
//   channel  signals                               direction
//   in       in_valid/in_ready, elem_a, elem_b,    request in
//            last_element
//   out      out_valid/out_ready, distance,        request out
//            saturated
//   cfg      cfg_write_en, cfg_write_data          metric_mode write
//
// Each pair runs prep, term and add; in canberra a pair that is not all zero runs
// the bit-serial divider for 33 steps in place of term. The last pair adds the
// result stage, after a digit-serial square root in euclidean mode unless saturated.
// rst is synchronous and clears mode, accumulator and output valid.
// A held result does not block new pairs; only the next result waits on out_ready.
module vector_distance_engine_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [vde_pkg::ElemW-1:0] elem_a,
  input  logic signed [vde_pkg::ElemW-1:0] elem_b,
  input  logic                          last_element,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vde_pkg::OutW-1:0]      distance,
  output logic                          saturated,
  input  logic                          cfg_write_en,
  input  logic [1:0]                    cfg_write_data
);

  vde_pkg::cmd_t cmd;
  vde_pkg::sts_t sts;

  vde_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd)
  );

  vde_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .in_valid       (in_valid),
    .elem_a         (elem_a),
    .elem_b         (elem_b),
    .last_element   (last_element),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .distance       (distance),
    .saturated      (saturated)
  );

  assign in_ready = cmd.in_ready;

  a_sat_max: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> distance == '1)
    else $error("saturated result not at maximum");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(out_valid && !out_ready))
    else $error("result overwritten before taken");

endmodule

FILE: design/vde_ctrl.sv
// Controller state machine for the vector distance engine.
module vde_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  input  vde_pkg::sts_t   sts,
  output vde_pkg::cmd_t   cmd
);

  vde_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vde_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      vde_pkg::ST_IDLE: begin
        if (in_valid) state_next = vde_pkg::ST_PREP;
      end
      vde_pkg::ST_PREP: begin
        state_next = sts.canb_div ? vde_pkg::ST_DIV_INIT : vde_pkg::ST_TERM;
      end
      vde_pkg::ST_TERM:     state_next = vde_pkg::ST_ADD;
      vde_pkg::ST_DIV_INIT: state_next = vde_pkg::ST_DIV;
      vde_pkg::ST_DIV: begin
        if (sts.div_done) state_next = vde_pkg::ST_ADD;
      end
      vde_pkg::ST_ADD: begin
        if (!sts.last) state_next = vde_pkg::ST_IDLE;
        else if (sts.sq_need) state_next = vde_pkg::ST_SQ_INIT;
        else state_next = vde_pkg::ST_FIN;
      end
      vde_pkg::ST_SQ_INIT:  state_next = vde_pkg::ST_SQ;
      vde_pkg::ST_SQ: begin
        if (sts.sq_done) state_next = vde_pkg::ST_FIN;
      end
      vde_pkg::ST_FIN: begin
        if (!sts.out_busy) state_next = vde_pkg::ST_IDLE;
      end
      default: state_next = vde_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      vde_pkg::ST_IDLE:     cmd.in_ready = 1'b1;
      vde_pkg::ST_PREP:     cmd.prep     = 1'b1;
      vde_pkg::ST_TERM:     cmd.term     = 1'b1;
      vde_pkg::ST_DIV_INIT: cmd.div_init = 1'b1;
      vde_pkg::ST_DIV:      cmd.div_step = 1'b1;
      vde_pkg::ST_ADD:      cmd.add      = 1'b1;
      vde_pkg::ST_SQ_INIT:  cmd.sq_init  = 1'b1;
      vde_pkg::ST_SQ:       cmd.sq_step  = 1'b1;
      vde_pkg::ST_FIN:      cmd.finish   = !sts.out_busy;
      default:              cmd = '0;
    endcase
  end

endmodule

FILE: design/vde_dpath.sv
// Datapath: difference, multiply, divider, accumulator, square root, output register.
module vde_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  vde_pkg::cmd_t                 cmd,
  output vde_pkg::sts_t                 sts,
  input  logic                          in_valid,
  input  logic signed [vde_pkg::ElemW-1:0] elem_a,
  input  logic signed [vde_pkg::ElemW-1:0] elem_b,
  input  logic                          last_element,
  input  logic                          cfg_write_en,
  input  logic [1:0]                    cfg_write_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [vde_pkg::OutW-1:0]      distance,
  output logic                          saturated
);

  localparam int MagW  = vde_pkg::MagW;
  localparam int AccW  = vde_pkg::AccW;
  localparam int OutW  = vde_pkg::OutW;
  localparam int NumW  = vde_pkg::NumW;
  localparam int RootW = vde_pkg::RootW;
  localparam int RemW  = RootW + 4;
  localparam int SrcW  = AccW + 16;
  localparam logic [AccW-1:0] OutMax = {{(AccW-OutW){1'b0}}, {OutW{1'b1}}};

  vde_pkg::mode_t mode_cfg, mode_r;
  logic signed [vde_pkg::ElemW-1:0] a_r, b_r;
  logic last_r;
  logic [MagW-1:0] d_r, den_r, running_max;
  logic zero_r;
  logic [2*MagW-1:0] term_r;
  logic [AccW-1:0] accumulator;
  logic overflow_seen;

  logic [NumW-1:0] div_num, div_q;
  logic [MagW-1:0] div_rem;
  logic [vde_pkg::DivCntW-1:0] div_cnt;

  logic [SrcW-1:0] sq_src;
  logic [RootW-1:0] root;
  logic [RemW-1:0] sq_rem;
  logic [vde_pkg::SqCntW-1:0] sq_cnt;

  // prep-stage magnitudes
  logic signed [MagW-1:0] diff_s, a_s, b_s;
  logic [MagW-1:0] d_c, ma_c, mb_c;
  assign a_s    = MagW'(a_r);
  assign b_s    = MagW'(b_r);
  assign diff_s = a_s - b_s;
  assign d_c    = diff_s[MagW-1] ? MagW'(-diff_s) : MagW'(diff_s);
  assign ma_c   = a_s[MagW-1] ? MagW'(-a_s) : MagW'(a_s);
  assign mb_c   = b_s[MagW-1] ? MagW'(-b_s) : MagW'(b_s);

  // divider step
  logic [MagW:0] div_sh, div_sub;
  logic div_ge;
  assign div_sh  = {div_rem, div_num[NumW-1]};
  assign div_ge  = div_sh >= {1'b0, den_r};
  assign div_sub = div_sh - {1'b0, den_r};

  // accumulate with clamp
  logic [AccW-1:0] add_val;
  logic [AccW:0] acc_sum;
  always_comb begin
    if (mode_r == vde_pkg::MODE_CANB) begin
      add_val = zero_r ? '0 : AccW'(div_q);
    end else begin
      add_val = AccW'(term_r);
    end
  end
  assign acc_sum = {1'b0, accumulator} + {1'b0, add_val};

  // square root step
  logic [RemW-1:0] sq_sh, sq_trial;
  logic sq_ge;
  assign sq_sh    = {sq_rem[RemW-3:0], sq_src[SrcW-1 -: 2]};
  assign sq_trial = {{(RemW-RootW-2){1'b0}}, root, 2'b01};
  assign sq_ge    = sq_sh >= sq_trial;

  // final result
  logic [OutW-1:0] dist_c;
  logic sat_c;
  always_comb begin
    dist_c = '0;
    sat_c  = 1'b0;
    if (overflow_seen) begin
      dist_c = '1;
      sat_c  = 1'b1;
    end else begin
      case (mode_r)
        vde_pkg::MODE_MANH: begin
          if (accumulator > (OutMax >> 8)) begin
            dist_c = '1;
            sat_c  = 1'b1;
          end else begin
            dist_c = {accumulator[OutW-9:0], 8'd0};
          end
        end
        vde_pkg::MODE_EUCL: dist_c = OutW'(root);
        vde_pkg::MODE_CHEB: dist_c = OutW'({running_max, 8'd0});
        default: begin
          if (accumulator > OutMax) begin
            dist_c = '1;
            sat_c  = 1'b1;
          end else begin
            dist_c = accumulator[OutW-1:0];
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_cfg      <= vde_pkg::MODE_MANH;
      accumulator   <= '0;
      running_max   <= '0;
      overflow_seen <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_write_en) mode_cfg <= vde_pkg::mode_t'(cfg_write_data);
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.add) begin
        if (acc_sum[AccW]) begin
          accumulator   <= '1;
          overflow_seen <= 1'b1;
        end else begin
          accumulator <= acc_sum[AccW-1:0];
        end
        if (d_r > running_max) running_max <= d_r;
      end
      if (cmd.finish) begin
        accumulator   <= '0;
        running_max   <= '0;
        overflow_seen <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_ready && in_valid) begin
      a_r    <= elem_a;
      b_r    <= elem_b;
      last_r <= last_element;
      mode_r <= mode_cfg;
    end
    if (cmd.prep) begin
      d_r    <= d_c;
      den_r  <= ma_c + mb_c;
      zero_r <= (a_r == '0) && (b_r == '0);
    end
    if (cmd.term) begin
      case (mode_r)
        vde_pkg::MODE_MANH: term_r <= (2*MagW)'(d_r);
        vde_pkg::MODE_EUCL: term_r <= d_r * d_r;
        default:            term_r <= '0;
      endcase
    end
    if (cmd.div_init) begin
      div_num <= {d_r, 16'd0};
      div_rem <= '0;
      div_q   <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      div_num <= {div_num[NumW-2:0], 1'b0};
      div_rem <= div_ge ? div_sub[MagW-1:0] : div_sh[MagW-1:0];
      div_q   <= {div_q[NumW-2:0], div_ge};
      div_cnt <= div_cnt + 1'b1;
    end
    if (cmd.sq_init) begin
      sq_src <= {accumulator, 16'd0};
      sq_rem <= '0;
      root   <= '0;
      sq_cnt <= '0;
    end
    if (cmd.sq_step) begin
      sq_src <= {sq_src[SrcW-3:0], 2'b00};
      sq_rem <= sq_ge ? (sq_sh - sq_trial) : sq_sh;
      root   <= {root[RootW-2:0], sq_ge};
      sq_cnt <= sq_cnt + 1'b1;
    end
    if (cmd.finish) begin
      distance  <= dist_c;
      saturated <= sat_c;
    end
  end

  always_comb begin
    sts.canb_div = (mode_r == vde_pkg::MODE_CANB) && !((a_r == '0) && (b_r == '0));
    sts.last     = last_r;
    sts.sq_need  = (mode_r == vde_pkg::MODE_EUCL) && !overflow_seen && !acc_sum[AccW];
    sts.div_done = div_cnt == vde_pkg::DivCntW'(NumW - 1);
    sts.sq_done  = sq_cnt == vde_pkg::SqCntW'(RootW - 1);
    sts.out_busy = out_valid && !out_ready;
  end

endmodule
